// ----- hdl/midi_file_note_extractor_assert.svh -----
// Assertion macros used by mfne_back.
`ifndef MIDI_FILE_NOTE_EXTRACTOR_ASSERT_SVH
`define MIDI_FILE_NOTE_EXTRACTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, a, b)
`define ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

// ----- hdl/mfne_pkg.sv -----
`default_nettype none
package mfne_pkg;
    localparam int CHANNELS = 16;
    localparam int KEY_W = 11;
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    typedef enum logic [1:0] {
        KIND_NOTE = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_MTHD = 2'd0,
        ERR_HEADER = 2'd1,
        ERR_MTRK = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_HEADER,
        OP_REJECT,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t op;
        logic [KEY_W-1:0] key;
        logic [6:0] vel;
        logic [31:0] tick;
        logic [EPOCH_W-1:0] epoch;
        logic [14:0] tpq;
        err_t err;
    } cmd_t;

    function automatic logic [7:0] hdr_magic(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0: r = 8'h4d;
            2'd1: r = 8'h54;
            2'd2: r = 8'h68;
            default: r = 8'h64;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] trk_magic(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0: r = 8'h4d;
            2'd1: r = 8'h54;
            2'd2: r = 8'h72;
            default: r = 8'h6b;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/mfne_fifo.sv -----
`default_nettype none
module mfne_fifo import mfne_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic push,
    input wire cmd_t push_data,
    input wire logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);
    cmd_t mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    assign head = mem[rd_ptr_reg];
    assign empty = (count_reg == 3'd0);
    assign full = (count_reg == 3'd4);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {2'b0, push} - {2'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- hdl/mfne_front.sv -----
`default_nettype none
module mfne_front import mfne_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic accept,
    input wire logic [7:0] data_byte,
    input wire logic end_of_file,
    output logic push,
    output cmd_t push_data
);
    typedef enum logic [4:0] {
        PH_MAGIC, PH_HSIZE, PH_FORMAT, PH_NTRK, PH_DIV, PH_HSKIP, PH_TMAGIC,
        PH_TSIZE, PH_DELTA, PH_STATUS, PH_METATYPE, PH_LEN, PH_SKIP, PH_DATA1,
        PH_DATA2, PH_ABANDON, PH_IDLE
    } phase_t;

    phase_t phase_reg, phase_next;
    logic [2:0] fcnt_reg, fcnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] tracks_reg, tracks_next;
    logic [31:0] chunk_reg, chunk_next, skip_reg, skip_next, tick_reg, tick_next;
    logic [7:0] rs_reg, rs_next, es_reg, es_next;
    logic [6:0] fd_reg, fd_next;
    logic [14:0] div_reg, div_next;
    logic mm_reg, mm_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;

    always_comb begin
        logic [2:0] cnt1;
        logic [31:0] vacc;
        logic vdone;
        logic [15:0] acc16;
        logic [7:0] st;
        logic reuse;
        logic [3:0] ty;
        logic [3:0] ch;
        logic trackph;

        phase_next = phase_reg;
        fcnt_next = fcnt_reg;
        acc_next = acc_reg;
        tracks_next = tracks_reg;
        chunk_next = chunk_reg;
        skip_next = skip_reg;
        tick_next = tick_reg;
        rs_next = rs_reg;
        es_next = es_reg;
        fd_next = fd_reg;
        div_next = div_reg;
        mm_next = mm_reg;
        epoch_next = epoch_reg;
        push = 1'b0;
        push_data = '0;
        push_data.epoch = epoch_reg;
        push_data.tpq = div_reg;
        push_data.tick = tick_reg;

        cnt1 = fcnt_reg + 3'd1;
        vacc = {acc_reg[24:0], data_byte[6:0]};
        vdone = !data_byte[7] || (cnt1 >= 3'd4);
        acc16 = {acc_reg[7:0], data_byte};
        st = data_byte;
        reuse = 1'b0;
        ty = es_reg[7:4];
        ch = es_reg[3:0];
        trackph = 1'b0;

        unique case (phase_reg)
            PH_MAGIC: begin
                if (data_byte != hdr_magic(fcnt_reg[1:0])) mm_next = 1'b1;
                fcnt_next = cnt1;
                if (cnt1 >= 3'd4) begin
                    if (mm_next) begin
                        push = 1'b1;
                        push_data.op = OP_REJECT;
                        push_data.err = ERR_MTHD;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_HSIZE;
                        fcnt_next = '0;
                        acc_next = '0;
                    end
                end
            end
            PH_HSIZE: begin
                acc_next = {acc_reg[23:0], data_byte};
                fcnt_next = cnt1;
                if (cnt1 >= 3'd4) begin
                    skip_next = (acc_next > 32'd6) ? acc_next - 32'd6 : '0;
                    phase_next = PH_FORMAT;
                    fcnt_next = '0;
                    acc_next = '0;
                end
            end
            PH_FORMAT, PH_NTRK, PH_DIV: begin
                acc_next = {16'b0, acc16};
                fcnt_next = cnt1;
                if (cnt1 >= 3'd2) begin
                    fcnt_next = '0;
                    acc_next = '0;
                    if (phase_reg == PH_FORMAT) begin
                        if (acc16 > 16'd1) begin
                            push = 1'b1;
                            push_data.op = OP_REJECT;
                            push_data.err = ERR_HEADER;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_NTRK;
                        end
                    end else if (phase_reg == PH_NTRK) begin
                        if (acc16 == 16'd0) begin
                            push = 1'b1;
                            push_data.op = OP_REJECT;
                            push_data.err = ERR_HEADER;
                            phase_next = PH_IDLE;
                        end else begin
                            tracks_next = acc16;
                            phase_next = PH_DIV;
                        end
                    end else if (acc16[15]) begin
                        push = 1'b1;
                        push_data.op = OP_REJECT;
                        push_data.err = ERR_HEADER;
                        phase_next = PH_IDLE;
                    end else begin
                        div_next = (acc16 != 16'd0) ? acc16[14:0] : 15'd1;
                        push = 1'b1;
                        push_data.op = OP_HEADER;
                        push_data.tpq = div_next;
                        phase_next = (skip_reg != 32'd0) ? PH_HSKIP : PH_TMAGIC;
                        mm_next = 1'b0;
                    end
                end
            end
            PH_HSKIP: begin
                if (skip_reg != 32'd0) skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0) begin
                    phase_next = PH_TMAGIC;
                    fcnt_next = '0;
                    acc_next = '0;
                end
            end
            PH_TMAGIC: begin
                if (data_byte != trk_magic(fcnt_reg[1:0])) mm_next = 1'b1;
                fcnt_next = cnt1;
                if (cnt1 >= 3'd4) begin
                    phase_next = PH_TSIZE;
                    fcnt_next = '0;
                    acc_next = '0;
                end
            end
            PH_TSIZE: begin
                acc_next = {acc_reg[23:0], data_byte};
                fcnt_next = cnt1;
                if (cnt1 >= 3'd4) begin
                    if (mm_reg) begin
                        push = 1'b1;
                        push_data.op = OP_REJECT;
                        push_data.err = ERR_MTRK;
                        phase_next = PH_IDLE;
                    end else begin
                        chunk_next = acc_next;
                        tick_next = '0;
                        rs_next = '0;
                        // Each track gets a fresh tag; a wrap wipes the store.
                        if (epoch_reg == EPOCH_MAX) begin
                            epoch_next = {{(EPOCH_W-1){1'b0}}, 1'b1};
                            push = 1'b1;
                            push_data.op = OP_CLEAR;
                        end else begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                        fcnt_next = '0;
                        acc_next = '0;
                        if (chunk_next == 32'd0) begin
                            if (tracks_reg != 16'd0) tracks_next = tracks_reg - 16'd1;
                            if (tracks_next == 16'd0) begin
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_TMAGIC;
                                mm_next = 1'b0;
                            end
                        end else begin
                            phase_next = PH_DELTA;
                        end
                    end
                end
            end
            PH_IDLE: begin
            end
            default: begin
                trackph = 1'b1;
                unique case (phase_reg)
                    PH_DELTA: begin
                        acc_next = vacc;
                        fcnt_next = cnt1;
                        if (vdone) begin
                            tick_next = tick_reg + vacc;
                            phase_next = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        if (!data_byte[7]) begin
                            st = rs_reg;
                            reuse = 1'b1;
                        end else if (data_byte < 8'hf0) begin
                            rs_next = data_byte;
                        end
                        if (!data_byte[7] && rs_reg == 8'd0) begin
                            phase_next = PH_ABANDON;
                        end else begin
                            es_next = st;
                            if (st == 8'hff) begin
                                phase_next = PH_METATYPE;
                            end else if (st == 8'hf0 || st == 8'hf7) begin
                                phase_next = PH_LEN;
                                fcnt_next = '0;
                                acc_next = '0;
                            end else if (st[7:4] == 4'hc || st[7:4] == 4'hd) begin
                                if (reuse) begin
                                    phase_next = PH_DELTA;
                                    fcnt_next = '0;
                                    acc_next = '0;
                                end else begin
                                    skip_next = 32'd1;
                                    phase_next = PH_SKIP;
                                end
                            end else if (reuse) begin
                                fd_next = data_byte[6:0];
                                phase_next = PH_DATA2;
                            end else begin
                                phase_next = PH_DATA1;
                            end
                        end
                    end
                    PH_METATYPE: begin
                        phase_next = PH_LEN;
                        fcnt_next = '0;
                        acc_next = '0;
                    end
                    PH_LEN: begin
                        acc_next = vacc;
                        fcnt_next = cnt1;
                        if (vdone) begin
                            skip_next = vacc;
                            if (vacc == 32'd0) begin
                                phase_next = PH_DELTA;
                                fcnt_next = '0;
                                acc_next = '0;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (skip_reg != 32'd0) skip_next = skip_reg - 32'd1;
                        if (skip_next == 32'd0) begin
                            phase_next = PH_DELTA;
                            fcnt_next = '0;
                            acc_next = '0;
                        end
                    end
                    PH_DATA1: begin
                        fd_next = data_byte[6:0];
                        phase_next = PH_DATA2;
                    end
                    PH_DATA2: begin
                        phase_next = PH_DELTA;
                        fcnt_next = '0;
                        acc_next = '0;
                        if ((ty == 4'h8 || ty == 4'h9) && ({1'b0, ch} < 5'(CHANNELS))) begin
                            push = 1'b1;
                            push_data.key = {ch, fd_reg};
                            push_data.vel = data_byte[6:0];
                            push_data.op = (ty == 4'h9 && data_byte != 8'd0)
                                ? OP_NOTE_ON : OP_NOTE_OFF;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase

        if (trackph) begin
            if (chunk_reg != 32'd0) chunk_next = chunk_reg - 32'd1;
            if (chunk_next == 32'd0) begin
                if (tracks_reg != 16'd0) tracks_next = tracks_reg - 16'd1;
                if (tracks_next == 16'd0) begin
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_TMAGIC;
                    fcnt_next = '0;
                    acc_next = '0;
                    mm_next = 1'b0;
                end
            end
        end

        if (end_of_file) begin
            if (!push && phase_next <= PH_DIV) begin
                push = 1'b1;
                push_data.op = OP_REJECT;
                push_data.err = (phase_next == PH_MAGIC) ? ERR_MTHD : ERR_HEADER;
            end
            phase_next = PH_MAGIC;
            fcnt_next = '0;
            acc_next = '0;
            tracks_next = '0;
            chunk_next = '0;
            skip_next = '0;
            tick_next = '0;
            rs_next = '0;
            es_next = '0;
            fd_next = '0;
            div_next = 15'd1;
            mm_next = 1'b0;
        end
        push = push && accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;
            fcnt_reg <= '0;
            acc_reg <= '0;
            tracks_reg <= '0;
            chunk_reg <= '0;
            skip_reg <= '0;
            tick_reg <= '0;
            rs_reg <= '0;
            es_reg <= '0;
            fd_reg <= '0;
            div_reg <= 15'd1;
            mm_reg <= 1'b0;
            epoch_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            fcnt_reg <= fcnt_next;
            acc_reg <= acc_next;
            tracks_reg <= tracks_next;
            chunk_reg <= chunk_next;
            skip_reg <= skip_next;
            tick_reg <= tick_next;
            rs_reg <= rs_next;
            es_reg <= es_next;
            fd_reg <= fd_next;
            div_reg <= div_next;
            mm_reg <= mm_next;
            epoch_reg <= epoch_next;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/mfne_back.sv -----
`default_nettype none
`include "midi_file_note_extractor_assert.svh"
module mfne_back import mfne_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire cmd_t head,
    input wire logic empty,
    output logic pop,
    output logic m_tvalid,
    input wire logic m_tready,
    output logic [103:0] m_tdata,
    output logic [1:0] m_tuser
);
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [31:0] start;
        logic [6:0] vel;
    } entry_t;

    entry_t mem [2**KEY_W];
    entry_t rdata_reg, fwd_data_reg, cur, wdata;
    logic [KEY_W-1:0] fwd_key_reg, waddr, clr_addr_reg;
    logic fwd_valid_reg, clr_active_reg, cmd_valid_reg;
    cmd_t cmd_reg;
    logic advance, proc, active, wen, emit;
    logic [31:0] dur;
    logic [36:0] dur20;
    logic m_tvalid_reg;
    logic [103:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;
    logic [103:0] res_data;
    logic [1:0] res_kind;

    assign advance = !m_tvalid_reg || m_tready;
    assign proc = cmd_valid_reg && advance && !clr_active_reg;
    assign pop = !clr_active_reg && !empty
        && !(cmd_valid_reg && cmd_reg.op == OP_CLEAR) && (!cmd_valid_reg || proc);

    assign cur = (fwd_valid_reg && fwd_key_reg == cmd_reg.key) ? fwd_data_reg : rdata_reg;
    assign active = (cur.tag == cmd_reg.epoch);
    assign dur = cmd_reg.tick - cur.start;
    assign dur20 = {1'b0, dur, 4'b0} + {3'b0, dur, 2'b0};

    always_comb begin
        wen = 1'b0;
        waddr = cmd_reg.key;
        wdata = '0;
        emit = 1'b0;
        res_kind = KIND_NOTE;
        res_data = '0;
        if (clr_active_reg) begin
            wen = 1'b1;
            waddr = clr_addr_reg;
        end else if (proc) begin
            case (cmd_reg.op)
                OP_NOTE_ON: begin
                    wen = 1'b1;
                    wdata.tag = cmd_reg.epoch;
                    wdata.start = cmd_reg.tick;
                    wdata.vel = cmd_reg.vel;
                end
                OP_NOTE_OFF: begin
                    if (active) begin
                        wen = 1'b1;
                        emit = 1'b1;
                        res_data[16:2] = cmd_reg.tpq;
                        res_data[23:17] = cmd_reg.key[6:0];
                        res_data[27:24] = cmd_reg.key[10:7];
                        res_data[34:28] = cur.vel;
                        res_data[66:35] = cur.start;
                        res_data[98:67] = dur;
                        res_data[99] = (dur20 < {22'b0, cmd_reg.tpq});
                    end
                end
                OP_HEADER: begin
                    emit = 1'b1;
                    res_kind = KIND_HEADER;
                    res_data[16:2] = cmd_reg.tpq;
                end
                OP_REJECT: begin
                    emit = 1'b1;
                    res_kind = KIND_REJECT;
                    res_data[1:0] = cmd_reg.err;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
        if (pop) begin
            rdata_reg <= mem[head.key];
            cmd_reg <= head;
        end
        if (wen && !clr_active_reg) begin
            fwd_key_reg <= waddr;
            fwd_data_reg <= wdata;
        end
        if (emit) begin
            m_tdata_reg <= res_data;
            m_tuser_reg <= res_kind;
        end
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg <= '0;
            fwd_valid_reg <= 1'b0;
            cmd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                fwd_valid_reg <= 1'b0;
                if (clr_addr_reg == '1) clr_active_reg <= 1'b0;
            end else if (proc && cmd_reg.op == OP_CLEAR) begin
                clr_active_reg <= 1'b1;
                clr_addr_reg <= '0;
            end else if (wen) begin
                fwd_valid_reg <= 1'b1;
            end
            if (pop) cmd_valid_reg <= 1'b1;
            else if (proc) cmd_valid_reg <= 1'b0;
            if (emit) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    `ASSERT_IMPL(a_clr_no_pop, aclk, aresetn, clr_active_reg, !pop && !emit)
    `ASSERT_NEXT(a_clr_start, aclk, aresetn, proc && cmd_reg.op == OP_CLEAR, clr_active_reg)
    `ASSERT_IMPL(a_kind_ok, aclk, aresetn, m_tvalid_reg, m_tuser_reg != 2'd3)
endmodule
`default_nettype wire

// ----- hdl/midi_file_note_extractor.sv -----
// Channel   Dir  Contents
// s_*       in   tdata[7:0] data_byte; tlast end_of_file
// m_*       out  tuser kind; tdata note/header/reject fields
// A four-entry command queue sits between the byte parser and the note
// store; one byte is taken per cycle while the queue is not full. Each
// note result costs one pass through the note store: a read when the
// command leaves the queue, then a write. After reset and on each wrap
// of the track tag all 2048 note store entries are swept; parsing
// continues until the queue fills. Reset is synchronous, active low.
`default_nettype none
module midi_file_note_extractor import mfne_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    output logic s_tready,
    input wire logic [7:0] s_tdata,   // data_byte
    input wire logic s_tlast,
    output logic m_tvalid,
    input wire logic m_tready,
    // error_code[1:0], ticks_per_quarter[16:2], note_number[23:17],
    // note_channel[27:24], velocity[34:28], start_tick[66:35],
    // duration_ticks[98:67], short_note[99], zero[103:100]
    output logic [103:0] m_tdata,
    output logic [1:0] m_tuser        // kind
);
    logic accept, push, pop, empty, full;
    cmd_t push_data, head;

    assign s_tready = !full;
    assign accept = s_tvalid && s_tready;

    mfne_front u_front (
        .aclk(aclk), .aresetn(aresetn), .accept(accept),
        .data_byte(s_tdata), .end_of_file(s_tlast),
        .push(push), .push_data(push_data)
    );

    mfne_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_data(push_data),
        .pop(pop), .head(head), .empty(empty), .full(full)
    );

    mfne_back u_back (
        .aclk(aclk), .aresetn(aresetn), .head(head), .empty(empty), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );
endmodule
`default_nettype wire
